// File: design/thms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thms_pkg
// Shared constants, pattern tables and types for the trace header scanner.
// ----------------------------------------------------------------------------
package thms_pkg;

  localparam int OFFSET_BITS   = 32;
  localparam int PATTERN_COUNT = 11;
  localparam int MAX_LEN       = 16;
  localparam int LEVEL_W       = $clog2(MAX_LEN + 1);
  localparam int PKT_OFF_W     = 32;
  localparam int DATE_IDX      = 8;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LEVEL_W-1:0]     level_t;

  typedef enum logic [2:0] {
    HDR_ISDN_XMIT,
    HDR_ISDN_RECV,
    HDR_WAN_XMIT,
    HDR_WAN_RECV,
    HDR_WAN_DIALOUT,
    HDR_ETHER
  } hdr_type_e;

  // last character of each string sits in the low byte
  localparam logic [MAX_LEN*8-1:0] PAT_TEXT [PATTERN_COUNT] = '{
    "PRI-XMIT-", "PRI-RCV-", "XMIT-", "RECV-", "XMIT:", "RECV:",
    "PPP-OUT", "PPP-IN", "Date:", "WD_DIAL\117UT_DISP:", "ETHER"
  };

  localparam level_t PAT_LEN [PATTERN_COUNT] = '{
    level_t'(9), level_t'(8), level_t'(5), level_t'(5), level_t'(5), level_t'(5),
    level_t'(7), level_t'(6), level_t'(5), level_t'(16), level_t'(5)
  };

  localparam hdr_type_e PAT_TYPE [PATTERN_COUNT] = '{
    HDR_ISDN_XMIT, HDR_ISDN_RECV, HDR_WAN_XMIT, HDR_WAN_RECV, HDR_WAN_XMIT,
    HDR_WAN_RECV, HDR_WAN_XMIT, HDR_WAN_RECV, HDR_WAN_DIALOUT, HDR_WAN_DIALOUT,
    HDR_ETHER
  };

  typedef struct packed {
    logic [PATTERN_COUNT-1:0] complete;
  } match_t;

  typedef struct packed {
    logic step;
    logic clear;
  } match_ctl_t;

  // expected character of pattern idx at match level lvl (lvl below length)
  function automatic logic [7:0] pat_char(input int idx, input level_t lvl);
    int sh;
    sh = (int'(PAT_LEN[idx]) - 1 - int'(lvl)) * 8;
    if (lvl < PAT_LEN[idx]) begin
      return PAT_TEXT[idx][sh +: 8];
    end
    return 8'h00;
  endfunction

endpackage
`default_nettype wire

// File: design/thms_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thms_matcher
// Per-pattern match levels: advance on the expected byte, drop to zero
// otherwise, flag completions; any non-Date completion or a clear request clears all levels.
// ----------------------------------------------------------------------------
module thms_matcher
  import thms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire match_ctl_t ctl_i,
  input  wire logic [7:0] byte_i,
  output match_t          match_o
);

  level_t level_q [PATTERN_COUNT];
  level_t level_d [PATTERN_COUNT];
  logic   any_hdr;

  always_comb begin
    match_o.complete = '0;
    any_hdr          = 1'b0;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      level_d[i] = '0;
      if (level_q[i] < PAT_LEN[i] && byte_i != 8'h00 && byte_i == pat_char(i, level_q[i]))
      begin
        if (level_q[i] + level_t'(1) == PAT_LEN[i]) begin
          match_o.complete[i] = 1'b1;
          if (i != DATE_IDX) begin
            any_hdr = 1'b1;
          end
        end else begin
          level_d[i] = level_q[i] + level_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PATTERN_COUNT; i++) level_q[i] <= '0;
    end else if (ctl_i.clear || (ctl_i.step && any_hdr)) begin
      for (int i = 0; i < PATTERN_COUNT; i++) level_q[i] <= '0;
    end else if (ctl_i.step) begin
      for (int i = 0; i < PATTERN_COUNT; i++) level_q[i] <= level_d[i];
    end
  end

endmodule
`default_nettype wire

// File: design/trace_header_magic_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trace_header_magic_scanner
// Byte-stream scanner for eleven fixed header strings; reports header type
// and packet start offset, or not-found at end of input.
// ----------------------------------------------------------------------------
// Path: an input request passes through the input register, then the
//   result register, before the result is valid.
// Throughput: one byte per cycle while the result port is not stalled; the match levels are registered in the matcher.
// Reset: rst_ni clears levels, Date mark, byte position and valid flags.
// End of input also returns all search state to reset values.
module trace_header_magic_scanner
  import thms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // end_of_input
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o    // [0] found, [3:1] header_type,
                                             // [35:4] packet_offset, [39:36] 0
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_eoi_q;
  offset_t          pos_q;
  logic             date_seen_q;
  offset_t          date_off_q;
  logic             out_valid_q;
  logic             found_q;
  hdr_type_e        type_q;
  logic [PKT_OFF_W-1:0] off_q;

  logic       fire;
  match_ctl_t ctl;
  match_t     match;

  offset_t    start [PATTERN_COUNT];
  logic       hit;
  hdr_type_e  hit_type;
  offset_t    hit_off;
  logic       date_cmp;
  logic       seen_eff;
  offset_t    date_eff;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign ctl.step        = fire && !in_eoi_q;
  assign ctl.clear       = fire && in_eoi_q;

  thms_matcher u_matcher (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .byte_i  (in_byte_q),
    .match_o (match)
  );

  always_comb begin
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      start[i] = pos_q + offset_t'(1) - offset_t'(PAT_LEN[i]);
    end
    date_cmp = match.complete[DATE_IDX];
    seen_eff = date_cmp || date_seen_q;
    date_eff = date_cmp ? start[DATE_IDX] : date_off_q;
    hit      = 1'b0;
    hit_type = HDR_ISDN_XMIT;
    hit_off  = '0;
    // walk downward so the lowest index wins
    for (int i = PATTERN_COUNT - 1; i >= 0; i--) begin
      if (i != DATE_IDX && match.complete[i]) begin
        hit      = 1'b1;
        hit_type = PAT_TYPE[i];
        if (i < DATE_IDX) begin
          hit_off = date_seen_q ? date_off_q : start[i];
        end else begin
          hit_off = seen_eff ? date_eff : start[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      date_seen_q <= 1'b0;
      date_off_q  <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire && (in_eoi_q || hit)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        if (in_eoi_q) begin
          pos_q       <= '0;
          date_seen_q <= 1'b0;
          date_off_q  <= '0;
        end else begin
          pos_q <= pos_q + offset_t'(1);
          if (hit) begin
            date_seen_q <= 1'b0;
            date_off_q  <= '0;
          end else if (date_cmp) begin
            date_seen_q <= 1'b1;
            date_off_q  <= start[DATE_IDX];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
    if (fire && (in_eoi_q || hit)) begin
      found_q <= !in_eoi_q;
      type_q  <= in_eoi_q ? HDR_ISDN_XMIT : hit_type;
      off_q   <= in_eoi_q ? '0 : PKT_OFF_W'(hit_off);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, off_q, type_q, found_q};

endmodule
`default_nettype wire

// File: tb/scan_result_checker.sv
// ----------------------------------------------------------------------------
// scan_result_checker
// Watches both stream ports of the header scanner. It tracks the match
// levels, the Date mark and the byte position for every accepted request,
// and queues the result each request should produce. Each accepted result
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module scan_result_checker
  import thms_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // end_of_input
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [39:0] m_axis_tdata_i,   // [0] found, [3:1] header_type,
                                             // [35:4] packet_offset, [39:36] 0
  output int               fail_count_o,
  output int               pending_o
);

  localparam int NUM_HDRS  = 11;
  localparam int DATE_SLOT = 8;

  typedef struct packed {
    logic        found;
    hdr_type_e   kind;
    logic [31:0] offset;
  } hdr_result_t;

  string hdr_text [NUM_HDRS] = '{
    "PRI-XMIT-", "PRI-RCV-", "XMIT-", "RECV-", "XMIT:", "RECV:",
    "PPP-OUT", "PPP-IN", "Date:", "WD_DIAL\117UT_DISP:", "ETHER"
  };

  hdr_type_e hdr_kind [NUM_HDRS] = '{
    HDR_ISDN_XMIT, HDR_ISDN_RECV, HDR_WAN_XMIT, HDR_WAN_RECV, HDR_WAN_XMIT,
    HDR_WAN_RECV, HDR_WAN_XMIT, HDR_WAN_RECV, HDR_WAN_DIALOUT, HDR_WAN_DIALOUT,
    HDR_ETHER
  };

  int          levels [NUM_HDRS];
  bit          date_seen;
  logic [31:0] date_offset;
  logic [31:0] byte_pos;
  hdr_result_t expected_q [$];

  task automatic clear_search();
    foreach (levels[i]) levels[i] = 0;
    date_seen   = 1'b0;
    date_offset = '0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic eoi);
    logic [31:0] pos;
    logic [31:0] start;
    int          lvl;
    int          len;
    bit          hit;
    hdr_result_t r;
    hit = 1'b0;
    pos = byte_pos;
    if (eoi) begin
      r = '0;
      expected_q.push_back(r);
      clear_search();
      byte_pos = '0;
      return;
    end
    byte_pos = pos + 32'd1;
    for (int i = 0; i < NUM_HDRS && !hit; i++) begin
      lvl = levels[i];
      len = hdr_text[i].len();
      if (lvl < len && b != 8'h00 && b == hdr_text[i][lvl]) begin
        lvl++;
        if (lvl >= len) begin
          start = pos + 32'd1 - 32'(len);
          if (i == DATE_SLOT) begin
            date_offset = start;
            date_seen   = 1'b1;
            levels[i]   = 0;
          end else begin
            r.found  = 1'b1;
            r.kind   = hdr_kind[i];
            r.offset = date_seen ? date_offset : start;
            expected_q.push_back(r);
            clear_search();
            hit = 1'b1;
          end
        end else begin
          levels[i] = lvl;
        end
      end else begin
        levels[i] = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hdr_result_t want;
    if (!rst_ni) begin
      clear_search();
      byte_pos = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        scan_byte(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result: expected none, actual found=%0b type=%0d offset=%0d",
                   $time, m_axis_tdata_i[0], m_axis_tdata_i[3:1], m_axis_tdata_i[35:4]);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata_i[0] !== want.found || m_axis_tdata_i[3:1] !== want.kind ||
              m_axis_tdata_i[35:4] !== want.offset || m_axis_tdata_i[39:36] !== 4'h0) begin
            fail_count_o++;
            $display("%0t: result mismatch: expected found=%0b type=%0d offset=%0d pad=0,",
                     $time, want.found, want.kind, want.offset);
            $display("%0t:   actual found=%0b type=%0d offset=%0d pad=%0h",
                     $time, m_axis_tdata_i[0], m_axis_tdata_i[3:1],
                     m_axis_tdata_i[35:4], m_axis_tdata_i[39:36]);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the trace header scanner: a short directed stream covering
// zero and all-ones bytes, end of input, Date restarts and a cut-off header,
// then random streams built mostly from header strings with noise, broken
// headers and end-of-input marks. Both ports idle at random.
// ----------------------------------------------------------------------------
module testbench;

  bit          clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int bytes_sent;
  bit calm;
  bit paused;
  int idx;
  int cut;
  int bad;

  string hdr_text [11] = '{
    "PRI-XMIT-", "PRI-RCV-", "XMIT-", "RECV-", "XMIT:", "RECV:",
    "PPP-OUT", "PPP-IN", "Date:", "WD_DIAL\117UT_DISP:", "ETHER"
  };
  string near_chars = "PRIXMTCVEDWOUNSHLa-_:te";

  trace_header_magic_scanner u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  scan_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 2) == 0) begin
      return near_chars[$urandom_range(0, near_chars.len() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    calm = (bytes_sent >= 220 && bytes_sent < 320);
    if (!calm && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'($urandom);
      s_axis_tlast_i  <= 1'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // first n characters of s; the one at position bad_pos is replaced by noise
  task automatic send_text(input string s, input int n, input int bad_pos);
    for (int k = 0; k < n; k++) begin
      send_byte((k == bad_pos) ? noise_byte() : s[k], 1'b0);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("Date:Date:PPP-IN", 16, -1);
    send_text("ETHER", 5, -1);
    send_text("RECV", 4, -1);
    send_byte(8'hFF, 1'b1);
    wait_drained();

    bytes_sent = 0;
    while (bytes_sent < 400) begin
      if (!paused && bytes_sent >= 340) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 75) begin
        repeat ($urandom_range(0, 3)) send_byte(noise_byte(), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          send_text("Date:", 5, -1);
          repeat ($urandom_range(0, 2)) send_byte(noise_byte(), 1'b0);
        end
        idx = $urandom_range(0, 10);
        cut = hdr_text[idx].len();
        bad = -1;
        case ($urandom_range(0, 9))
          0: cut = $urandom_range(1, cut - 1);
          1: bad = $urandom_range(0, cut - 1);
          default: ;
        endcase
        send_text(hdr_text[idx], cut, bad);
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(noise_byte(), 1'b0);
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'b1);
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench failed");
    $finish;
  end

endmodule

// File: trace_header_magic_scanner.f
design/thms_pkg.sv
design/thms_matcher.sv
design/trace_header_magic_scanner.sv
tb/scan_result_checker.sv
tb/testbench.sv
